// ===== rtl/core/crpg_pkg.sv =====
// Package for the concentric ring point generator.
// Holds the shared types, the register codes and the fixed-point constants.
// No dependencies.
package crpg_pkg;

  // Layout limits and trig precision
  localparam int unsigned MaxRings     = 64;
  localparam int unsigned TrigFracBits = 15;

  // Register indexes on the configuration port
  localparam logic [2:0] CFG_CENTRE_X    = 3'd0;
  localparam logic [2:0] CFG_CENTRE_Y    = 3'd1;
  localparam logic [2:0] CFG_CENTRE_Z    = 3'd2;
  localparam logic [2:0] CFG_INIT_COUNT  = 3'd3;
  localparam logic [2:0] CFG_INIT_ANGLE  = 3'd4;
  localparam logic [2:0] CFG_RING_LEVELS = 3'd5;
  localparam logic [2:0] CFG_RADIUS_STEP = 3'd6;

  // Q30 constants for the sine series
  localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'd1073741824;

  // Reciprocals for exact floor division of 32-bit values by 72, 42, 20 and 6
  localparam int unsigned Sh72 = 39;
  localparam int unsigned Sh42 = 38;
  localparam int unsigned Sh20 = 37;
  localparam int unsigned Sh6  = 35;
  localparam logic [32:0] RECIP72 = 33'(((64'd1 << Sh72) + 64'd71) / 64'd72);
  localparam logic [32:0] RECIP42 = 33'(((64'd1 << Sh42) + 64'd41) / 64'd42);
  localparam logic [32:0] RECIP20 = 33'(((64'd1 << Sh20) + 64'd19) / 64'd20);
  localparam logic [32:0] RECIP6  = 33'(((64'd1 << Sh6) + 64'd5) / 64'd6);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_PUT
  } ctl_state_e;

  typedef enum logic [2:0] {
    CU_IDLE,
    CU_DIV,
    CU_TRIG,
    CU_RAD,
    CU_OFFX,
    CU_OFFY
  } cu_state_e;

  // Request to the point unit
  typedef struct packed {
    logic        start;
    logic [5:0]  ring;
    logic [13:0] pt;
    logic [13:0] count;
  } calc_req_t;

  // Answer from the point unit
  typedef struct packed {
    logic        done;
    logic [31:0] x;
    logic [31:0] y;
  } calc_rsp_t;

  // One result beat
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [5:0]  ring;
    logic [13:0] pt;
    logic        last;
    logic        valid;
  } res_t;

endpackage

// ===== rtl/core/crpg_point_unit.sv =====
// Point unit: angle division, sine and cosine series and offset scaling.
// All products go through one shared 33x32 multiplier under a small sequencer.
// Depends on crpg_pkg.
module crpg_point_unit
  import crpg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  calc_req_t   req_i,
  input  logic [15:0] init_angle_i,
  input  logic [23:0] radius_step_i,
  input  logic [31:0] centre_x_i,
  input  logic [31:0] centre_y_i,
  output calc_rsp_t   rsp_o
);

  localparam int unsigned T = TrigFracBits;

  cu_state_e state_q, state_d;
  logic [3:0]  cnt_q;
  logic        pass_q;
  logic        done_q;

  logic [5:0]  ring_q;
  logic [15:0] rem_q;
  logic [15:0] quo_q;
  logic [14:0] div_q;
  logic [15:0] angle_q;
  logic [31:0] x_q, x2_q, p_q;
  logic [30:0] k_q;
  logic [T:0]  mag_s_q, mag_c_q;
  logic        neg_s_q, neg_c_q;
  logic [29:0] r_q;
  logic [31:0] px_q, py_q;

  // Restoring division step
  logic [15:0] trial;
  logic        qbit;
  assign trial = {rem_q[14:0], quo_q[15]};
  assign qbit  = trial >= {1'b0, div_q};

  // Angle of the current pass and its folded quarter-turn position
  logic [15:0] ang;
  logic [14:0] tq;
  assign ang = pass_q ? angle_q + 16'd16384 : angle_q;
  assign tq  = ang[14] ? 15'd16384 - {1'b0, ang[13:0]} : {1'b0, ang[13:0]};

  // Shared multiplier operand selection
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] prod;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      CU_TRIG: begin
        case (cnt_q)
          4'd0: begin mul_a = {18'd0, tq}; mul_b = HALF_PI_Q30[31:0]; end
          4'd1: begin mul_a = {1'b0, x_q}; mul_b = x_q; end
          4'd2: begin mul_a = RECIP72; mul_b = x2_q; end
          4'd4: begin mul_a = RECIP42; mul_b = p_q; end
          4'd6: begin mul_a = RECIP20; mul_b = p_q; end
          4'd8: begin mul_a = RECIP6; mul_b = p_q; end
          4'd9: begin mul_a = {2'd0, k_q}; mul_b = x_q; end
          default: begin mul_a = {2'd0, k_q}; mul_b = x2_q; end
        endcase
      end
      CU_RAD: begin mul_a = {27'd0, ring_q}; mul_b = {8'd0, radius_step_i}; end
      CU_OFFX: begin mul_a = 33'(mag_c_q); mul_b = {2'd0, r_q}; end
      CU_OFFY: begin mul_a = 33'(mag_s_q); mul_b = {2'd0, r_q}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign prod = {32'd0, mul_a} * {33'd0, mul_b};

  // Clamp and rounding of the sine value to the trig format
  logic [33:0] s_raw, s_clip, s_rnd;
  assign s_raw  = prod[63:30];
  assign s_clip = (s_raw > {3'd0, ONE_Q30}) ? {3'd0, ONE_Q30} : s_raw;
  assign s_rnd  = (s_clip + (34'd1 << (29 - T))) >> (30 - T);

  // Offset scaling with round half up on the magnitude, then the sign
  logic [64:0] w_full;
  logic [31:0] w_mag;
  logic        w_neg;
  logic [31:0] w_off;
  assign w_full = prod + (65'd1 << (T - 1));
  assign w_mag  = w_full[T+31:T];
  assign w_neg  = (state_q == CU_OFFX) ? neg_c_q : neg_s_q;
  assign w_off  = w_neg ? 32'd0 - w_mag : w_mag;

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CU_IDLE: if (req_i.start) state_d = CU_DIV;
      CU_DIV:  if (cnt_q == 4'd15) state_d = CU_TRIG;
      CU_TRIG: if (cnt_q == 4'd9 && pass_q) state_d = CU_RAD;
      CU_RAD:  state_d = CU_OFFX;
      CU_OFFX: state_d = CU_OFFY;
      CU_OFFY: state_d = CU_IDLE;
      default: state_d = CU_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CU_IDLE;
      cnt_q   <= '0;
      pass_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == CU_OFFY);
      if (state_q != state_d) begin
        cnt_q <= '0;
      end else if (state_q == CU_DIV) begin
        cnt_q <= cnt_q + 4'd1;
      end else if (state_q == CU_TRIG) begin
        cnt_q <= (cnt_q == 4'd9) ? 4'd0 : cnt_q + 4'd1;
      end
      if (state_q == CU_IDLE) begin
        pass_q <= 1'b0;
      end else if (state_q == CU_TRIG && cnt_q == 4'd9) begin
        pass_q <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      CU_IDLE: begin
        ring_q <= req_i.ring;
        rem_q  <= {1'b0, req_i.pt, 1'b0};
        quo_q  <= {2'd0, req_i.count};
        div_q  <= {req_i.count, 1'b0};
      end
      CU_DIV: begin
        rem_q <= qbit ? trial - {1'b0, div_q} : trial;
        quo_q <= {quo_q[14:0], qbit};
        if (cnt_q == 4'd15) angle_q <= init_angle_i + {quo_q[14:0], qbit};
      end
      CU_TRIG: begin
        case (cnt_q)
          4'd0: x_q  <= prod[45:14];
          4'd1: x2_q <= prod[61:30];
          4'd2: k_q  <= ONE_Q30 - 31'(prod >> Sh72);
          4'd4: k_q  <= ONE_Q30 - 31'(prod >> Sh42);
          4'd6: k_q  <= ONE_Q30 - 31'(prod >> Sh20);
          4'd8: k_q  <= ONE_Q30 - 31'(prod >> Sh6);
          4'd9: begin
            if (pass_q) begin
              mag_c_q <= s_rnd[T:0];
              neg_c_q <= ang[15];
            end else begin
              mag_s_q <= s_rnd[T:0];
              neg_s_q <= ang[15];
            end
          end
          default: p_q <= prod[61:30];
        endcase
      end
      CU_RAD:  r_q  <= prod[29:0];
      CU_OFFX: px_q <= centre_x_i + w_off;
      CU_OFFY: py_q <= centre_y_i + w_off;
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.x    = px_q;
  assign rsp_o.y    = py_q;

endmodule

// ===== rtl/core/concentric_ring_point_generator_core.sv =====
// Each input beat asks for the next point of a concentric ring layout (or a restart at the
// centre) and yields exactly one result beat. Centre points, finished-sequence beats and
// out-of-layout beats pass from the staging register to the output register. A ring point
// first goes through the point unit: bit-serial angle division, sine and cosine on the
// shared multiplier, radius and offsets on the same multiplier, and the answer handed back;
// it then passes through staging to the output register. The shared multiplier and the
// divider serve one item at a time, and a new beat is taken only once the last result has
// left staging. A finished result waits in the output register while the next beat is taken;
// a second result waits in staging, and the input stalls, until the output beat is taken.
//
// Top level of the concentric ring point generator; uses crpg_pkg and crpg_point_unit.
module concentric_ring_point_generator_core
  import crpg_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration write channel
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  // Input stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [0] restart, [7:1] zero
  // Output stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [119:0] m_axis_tdata_o,   // point_x, point_y, point_z, ring_index,
                                         // point_index, zero fill
  output logic         m_axis_tlast_o,   // last_point
  output logic         m_axis_tuser_o    // point_valid
);

  // Configuration registers
  logic [31:0] centre_x_q, centre_y_q, centre_z_q;
  logic [7:0]  init_count_q;
  logic [15:0] init_angle_q;
  logic [6:0]  ring_levels_q;
  logic [23:0] radius_step_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_x_q    <= '0;
      centre_y_q    <= '0;
      centre_z_q    <= '0;
      init_count_q  <= '0;
      init_angle_q  <= '0;
      ring_levels_q <= '0;
      radius_step_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CENTRE_X:    centre_x_q    <= cfg_data_i;
        CFG_CENTRE_Y:    centre_y_q    <= cfg_data_i;
        CFG_CENTRE_Z:    centre_z_q    <= cfg_data_i;
        CFG_INIT_COUNT:  init_count_q  <= cfg_data_i[7:0];
        CFG_INIT_ANGLE:  init_angle_q  <= cfg_data_i[15:0];
        CFG_RING_LEVELS: ring_levels_q <= cfg_data_i[6:0];
        CFG_RADIUS_STEP: radius_step_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // Layout properties
  logic [6:0]  levels;
  logic        degen;
  logic [13:0] count;

  ctl_state_e  state_q, state_d;
  logic [5:0]  ring_q, ring_d;
  logic [13:0] pt_q, pt_d;
  logic        started_q, started_d;
  logic        done_q, done_d;
  res_t        res_q, res_d;
  res_t        out_q, out_d;
  logic        out_valid_q, out_valid_d;
  calc_req_t   req;
  calc_rsp_t   rsp;
  logic        s_acc;

  assign levels = (ring_levels_q > 7'(MaxRings)) ? 7'(MaxRings) : ring_levels_q;
  assign degen  = (init_count_q <= 8'd2) || (levels <= 7'd1) || (radius_step_q == 24'd0);
  assign count  = {6'd0, init_count_q} * {8'd0, ring_q};

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // Sequence control and result staging
  always_comb begin
    state_d     = state_q;
    ring_d      = ring_q;
    pt_d        = pt_q;
    started_d   = started_q;
    done_d      = done_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    req.start   = 1'b0;
    req.ring    = ring_q;
    req.pt      = pt_q;
    req.count   = count;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          res_d   = '0;
          state_d = ST_PUT;
          if (s_axis_tdata_i[0] || !started_q) begin
            started_d   = 1'b1;
            res_d.x     = centre_x_q;
            res_d.y     = centre_y_q;
            res_d.z     = centre_z_q;
            res_d.valid = 1'b1;
            if (degen) begin
              done_d     = 1'b1;
              res_d.last = 1'b1;
            end else begin
              done_d = 1'b0;
              ring_d = 6'd1;
              pt_d   = '0;
            end
          end else if (done_q) begin
            done_d = 1'b1;
          end else if (degen || ring_q == 6'd0 || {1'b0, ring_q} >= levels ||
                       pt_q >= count) begin
            done_d = 1'b1;
          end else begin
            req.start   = 1'b1;
            state_d     = ST_CALC;
            res_d.z     = centre_z_q;
            res_d.ring  = ring_q;
            res_d.pt    = pt_q;
            res_d.valid = 1'b1;
            if ({1'b0, pt_q} + 15'd1 < {1'b0, count}) begin
              pt_d = pt_q + 14'd1;
            end else if ({1'b0, ring_q} + 7'd1 < levels) begin
              ring_d = ring_q + 6'd1;
              pt_d   = '0;
            end else begin
              res_d.last = 1'b1;
              done_d     = 1'b1;
            end
          end
        end
      end
      ST_CALC: begin
        if (rsp.done) begin
          res_d.x = rsp.x;
          res_d.y = rsp.y;
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ring_q      <= '0;
      pt_q        <= '0;
      started_q   <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ring_q      <= ring_d;
      pt_q        <= pt_d;
      started_q   <= started_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

  crpg_point_unit u_point (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .init_angle_i  (init_angle_q),
    .radius_step_i (radius_step_q),
    .centre_x_i    (centre_x_q),
    .centre_y_i    (centre_y_q),
    .rsp_o         (rsp)
  );

  // Output beat
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, out_q.pt, out_q.ring, out_q.z, out_q.y, out_q.x};
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tuser_o  = out_q.valid;

  // The point unit only answers while a ring point is being worked on
  a_done_in_calc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> state_q == ST_CALC)
    else $error("point unit answered outside a calculation");

  // One item at a time: no new beat right after one is taken
  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready_o)
    else $error("input taken while an item is in work");

  // A not valid result carries only zeros
  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == '0 && !m_axis_tlast_o))
    else $error("not valid result carries data");

endmodule
